@@ rtl/core/nirpd_pkg.sv @@
// nirpd_pkg: shared constants and types for the nec ir pulse decoder
// width windows, queue default, and the classified-edge record
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package nirpd_pkg;

    localparam int unsigned WIDTH_W = 16;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CNT_W   = 7;
    localparam int unsigned NUM_BYTES = 4;

    // exclusive width windows in microseconds
    localparam logic [WIDTH_W-1:0] ONE_LO   = 16'd1550;
    localparam logic [WIDTH_W-1:0] ONE_HI   = 16'd1750;
    localparam logic [WIDTH_W-1:0] ZERO_LO  = 16'd460;
    localparam logic [WIDTH_W-1:0] ZERO_HI  = 16'd660;
    localparam logic [WIDTH_W-1:0] LEAD_LO  = 16'd8000;
    localparam logic [WIDTH_W-1:0] LEAD_HI  = 16'd10000;
    localparam logic [WIDTH_W-1:0] SPACE_LO = 16'd3500;
    localparam logic [WIDTH_W-1:0] SPACE_HI = 16'd5500;
    localparam logic [WIDTH_W-1:0] RPT_LO   = 16'd1500;

    localparam logic [CNT_W-1:0] DATA_EDGES = 7'd64;
    localparam logic [CNT_W-1:0] END_EDGE   = 7'd65;
    localparam int unsigned EDGES_PER_BYTE  = 16;
    localparam int unsigned BYTE_SEL_LSB    = $clog2(EDGES_PER_BYTE);

    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    typedef struct packed {
        logic level;
        logic is_one;
        logic is_zero;
        logic is_lead;
        logic is_space;
        logic is_rpt;
    } edge_cls_t;

endpackage

`default_nettype wire

@@ rtl/core/nec_ir_pulse_decoder_core.sv @@
// nec_ir_pulse_decoder_core: top level of the nec ir pulse decoder
// instantiates nirpd_front, nirpd_queue, nirpd_back; uses nirpd_pkg
//
//   channel   direction   handshake                     payload
//   item      in          item_valid / item_ready       line_level, pulse_width
//   result    out         result_valid / result_ready   frame_done .. repeat_count
//
// one transaction per cycle sustained while result_ready stays high; one result per accepted edge
// the window compare is registered into the queue, then the state update into
//   the result register
// reset clears the state machine, counters, data bytes and the queue
// a stalled result holds the back end; the queue then takes up to QUEUE_DEPTH
//   more transactions before item_ready drops
`timescale 1ns / 1ps
`default_nettype none

module nec_ir_pulse_decoder_core #(
    parameter int unsigned QUEUE_DEPTH = nirpd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              item_valid,
    output logic                                   item_ready,
    input  wire logic                              line_level,
    input  wire logic [nirpd_pkg::WIDTH_W-1:0]     pulse_width,
    output logic                                   result_valid,
    input  wire logic                              result_ready,
    output logic                                   frame_done,
    output logic                                   repeat_done,
    output logic                                   protocol_error,
    output logic [nirpd_pkg::BYTE_W-1:0]           first_byte,
    output logic [nirpd_pkg::BYTE_W-1:0]           second_byte,
    output logic [nirpd_pkg::BYTE_W-1:0]           third_byte,
    output logic [nirpd_pkg::BYTE_W-1:0]           fourth_byte,
    output logic [nirpd_pkg::BYTE_W-1:0]           repeat_count
);

    nirpd_pkg::edge_cls_t front_cls;
    nirpd_pkg::edge_cls_t back_cls;
    logic q_valid;
    logic q_ready;

    nirpd_front u_front (
        .line_level  (line_level),
        .pulse_width (pulse_width),
        .cls         (front_cls)
    );

    nirpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (item_valid),
        .push_ready (item_ready),
        .push_data  (front_cls),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (back_cls)
    );

    nirpd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cls_valid      (q_valid),
        .cls_ready      (q_ready),
        .cls            (back_cls),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .frame_done     (frame_done),
        .repeat_done    (repeat_done),
        .protocol_error (protocol_error),
        .first_byte     (first_byte),
        .second_byte    (second_byte),
        .third_byte     (third_byte),
        .fourth_byte    (fourth_byte),
        .repeat_count   (repeat_count)
    );

endmodule

`default_nettype wire

@@ rtl/core/nirpd_front.sv @@
// nirpd_front: judges one edge width against all nec windows
// depends on nirpd_pkg
`timescale 1ns / 1ps
`default_nettype none

module nirpd_front (
    input  wire logic                             line_level,
    input  wire logic [nirpd_pkg::WIDTH_W-1:0]    pulse_width,
    output nirpd_pkg::edge_cls_t                  cls
);

    always_comb
    begin
        cls.level    = line_level;
        cls.is_one   = (pulse_width > nirpd_pkg::ONE_LO) && (pulse_width < nirpd_pkg::ONE_HI);
        cls.is_zero  = (pulse_width > nirpd_pkg::ZERO_LO) && (pulse_width < nirpd_pkg::ZERO_HI);
        cls.is_lead  = (pulse_width > nirpd_pkg::LEAD_LO) && (pulse_width < nirpd_pkg::LEAD_HI);
        cls.is_space = (pulse_width > nirpd_pkg::SPACE_LO)
                       && (pulse_width < nirpd_pkg::SPACE_HI);
        cls.is_rpt   = (pulse_width > nirpd_pkg::RPT_LO) && (pulse_width < nirpd_pkg::SPACE_LO);
    end

endmodule

`default_nettype wire

@@ rtl/core/nirpd_queue.sv @@
// nirpd_queue: small register fifo of classified edges between front and back
// depends on nirpd_pkg
`timescale 1ns / 1ps
`default_nettype none

module nirpd_queue #(
    parameter int unsigned DEPTH = nirpd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push_valid,
    output logic                       push_ready,
    input  wire nirpd_pkg::edge_cls_t  push_data,
    output logic                       pop_valid,
    input  wire logic                  pop_ready,
    output nirpd_pkg::edge_cls_t       pop_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned FILL_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(DEPTH);

    nirpd_pkg::edge_cls_t entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic push, pop;

    assign push_ready = (fill_reg != FULL_FILL);
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/nirpd_back.sv @@
// nirpd_back: leader/data state machine, byte shifter and result register
// depends on nirpd_pkg
`timescale 1ns / 1ps
`default_nettype none

module nirpd_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cls_valid,
    output logic                                   cls_ready,
    input  wire nirpd_pkg::edge_cls_t              cls,
    output logic                                   result_valid,
    input  wire logic                              result_ready,
    output logic                                   frame_done,
    output logic                                   repeat_done,
    output logic                                   protocol_error,
    output logic [nirpd_pkg::BYTE_W-1:0]           first_byte,
    output logic [nirpd_pkg::BYTE_W-1:0]           second_byte,
    output logic [nirpd_pkg::BYTE_W-1:0]           third_byte,
    output logic [nirpd_pkg::BYTE_W-1:0]           fourth_byte,
    output logic [nirpd_pkg::BYTE_W-1:0]           repeat_count
);

    localparam int unsigned CW = nirpd_pkg::CNT_W;
    localparam int unsigned BW = nirpd_pkg::BYTE_W;

    // leader phase codes held in the edge counter
    localparam logic [CW-1:0] LDR_WAIT_FALL  = 7'd0;
    localparam logic [CW-1:0] LDR_MARK       = 7'd1;
    localparam logic [CW-1:0] LDR_SPACE      = 7'd2;
    localparam logic [CW-1:0] LDR_RPT_MARK   = 7'd3;

    logic          data_phase_reg, data_phase_next;
    logic [CW-1:0] edge_cnt_reg, edge_cnt_next;
    logic [BW-1:0] data_reg [nirpd_pkg::NUM_BYTES];
    logic [BW-1:0] data_next [nirpd_pkg::NUM_BYTES];
    logic [BW-1:0] repeats_reg, repeats_next;
    logic          res_valid_reg;
    logic          fdone_reg, fdone_next;
    logic          rdone_reg, rdone_next;
    logic          err_reg, err_next;
    logic [CW-1:0] cnt_inc;
    logic [CW-1:0] cnt_m1;
    logic [1:0]    byte_sel;
    logic          take;

    assign cls_ready = !res_valid_reg || result_ready;
    assign take      = cls_valid && cls_ready;
    assign cnt_inc   = edge_cnt_reg + 1'b1;
    assign cnt_m1    = cnt_inc - 1'b1;
    assign byte_sel  = cnt_m1[nirpd_pkg::BYTE_SEL_LSB +: 2];

    always_comb
    begin
        data_phase_next = data_phase_reg;
        edge_cnt_next   = edge_cnt_reg;
        repeats_next    = repeats_reg;
        data_next       = data_reg;
        fdone_next      = 1'b0;
        rdone_next      = 1'b0;
        err_next        = 1'b0;
        if (data_phase_reg)
        begin
            edge_cnt_next = cnt_inc;
            if (!cls.level)
            begin
                if (!cls.is_one && !cls.is_zero)
                begin
                    err_next = 1'b1;
                end
                else if (cnt_inc != '0 && cnt_inc <= nirpd_pkg::DATA_EDGES)
                begin
                    data_next[byte_sel] = {data_reg[byte_sel][BW-2:0], cls.is_one};
                end
            end
            if (err_next)
            begin
                data_phase_next = 1'b0;
                edge_cnt_next   = '0;
                repeats_next    = '0;
            end
            else if (cnt_inc == nirpd_pkg::END_EDGE)
            begin
                data_phase_next = 1'b0;
                edge_cnt_next   = '0;
                repeats_next    = repeats_reg + 1'b1;
                fdone_next      = 1'b1;
            end
        end
        else
        begin
            case (edge_cnt_reg)
                LDR_WAIT_FALL:
                begin
                    if (!cls.level)
                    begin
                        edge_cnt_next = LDR_MARK;
                    end
                end
                LDR_MARK:
                begin
                    if (cls.is_lead)
                    begin
                        edge_cnt_next = LDR_SPACE;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                LDR_SPACE:
                begin
                    if (cls.is_space)
                    begin
                        data_phase_next = 1'b1;
                        edge_cnt_next   = '0;
                        repeats_next    = '0;
                    end
                    else if (cls.is_rpt)
                    begin
                        edge_cnt_next = LDR_RPT_MARK;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                LDR_RPT_MARK:
                begin
                    if (cls.is_zero)
                    begin
                        repeats_next  = repeats_reg + 1'b1;
                        edge_cnt_next = LDR_WAIT_FALL;
                        rdone_next    = 1'b1;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                default:
                begin
                    edge_cnt_next = LDR_WAIT_FALL;
                end
            endcase
            if (err_next)
            begin
                data_phase_next = 1'b0;
                edge_cnt_next   = '0;
                repeats_next    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_phase_reg <= 1'b0;
            edge_cnt_reg   <= '0;
            repeats_reg    <= '0;
            data_reg       <= '{default: '0};
            res_valid_reg  <= 1'b0;
            fdone_reg      <= 1'b0;
            rdone_reg      <= 1'b0;
            err_reg        <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                data_phase_reg <= data_phase_next;
                edge_cnt_reg   <= edge_cnt_next;
                repeats_reg    <= repeats_next;
                data_reg       <= data_next;
                fdone_reg      <= fdone_next;
                rdone_reg      <= rdone_next;
                err_reg        <= err_next;
                res_valid_reg  <= 1'b1;
            end
            else if (result_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid   = res_valid_reg;
    assign frame_done     = fdone_reg;
    assign repeat_done    = rdone_reg;
    assign protocol_error = err_reg;
    assign first_byte     = data_reg[0];
    assign second_byte    = data_reg[1];
    assign third_byte     = data_reg[2];
    assign fourth_byte    = data_reg[3];
    assign repeat_count   = repeats_reg;

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// tb: self-checking testbench for nec_ir_pulse_decoder_core
// directed edge table, then random frames, repeat codes and noise, checked per edge
// depends on nirpd_pkg and the decoder rtl
`timescale 1ns / 1ps

module tb;

    localparam int unsigned WW = nirpd_pkg::WIDTH_W;
    localparam int unsigned BW = nirpd_pkg::BYTE_W;
    localparam int unsigned CW = nirpd_pkg::CNT_W;
    localparam int unsigned NB = nirpd_pkg::NUM_BYTES;

    localparam logic LVL_LOW  = 1'b0;
    localparam logic LVL_HIGH = 1'b1;

    // leader progress while not in the data phase
    localparam logic [CW-1:0] AWAIT_FALL  = 7'd0;
    localparam logic [CW-1:0] AWAIT_MARK  = 7'd1;
    localparam logic [CW-1:0] AWAIT_SPACE = 7'd2;
    localparam logic [CW-1:0] AWAIT_TAIL  = 7'd3;

    localparam int RANDOM_EDGES     = 1450;
    localparam int PAUSE_AT_EDGES   = 700;
    localparam int LONG_HOLD_AT     = 400;
    localparam int LONG_HOLD_CYCLES = 150;
    localparam int MAX_GAP          = 12;
    localparam int STALL_LIMIT      = 1000;
    localparam int DRAIN_CYCLES     = 10;

    typedef enum int {FLAW_NONE, FLAW_BAD_BIT, FLAW_EXTRA_EDGE, FLAW_FALLING_END} frame_flaw_t;

    typedef struct packed {
        logic                    frame_done;
        logic                    repeat_done;
        logic                    protocol_error;
        logic [NB-1:0][BW-1:0]   data;
        logic [BW-1:0]           repeat_count;
    } ir_result_t;

    typedef struct packed {
        logic           lvl;
        logic [WW-1:0]  w;
        logic           typed;
        logic           fd;
        logic           rd;
        logic           er;
        logic [BW-1:0]  rc;
    } directed_row_t;

    localparam int N_DIRECTED = 27;
    localparam directed_row_t DIRECTED[N_DIRECTED] = '{
        '{LVL_HIGH, 16'd0,                       1'b1, 1'b0, 1'b0, 1'b0, 8'd0},
        '{LVL_LOW,  16'hffff,                    1'b1, 1'b0, 1'b0, 1'b0, 8'd0},
        '{LVL_HIGH, nirpd_pkg::LEAD_LO,          1'b1, 1'b0, 1'b0, 1'b1, 8'd0},
        '{LVL_LOW,  16'd0,                       1'b0, 1'b0, 1'b0, 1'b0, 8'd0},
        '{LVL_HIGH, nirpd_pkg::LEAD_HI,          1'b1, 1'b0, 1'b0, 1'b1, 8'd0},
        '{LVL_HIGH, 16'hffff,                    1'b1, 1'b0, 1'b0, 1'b0, 8'd0},
        '{LVL_LOW,  16'd40000,                   1'b0, 1'b0, 1'b0, 1'b0, 8'd0},
        '{LVL_LOW,  nirpd_pkg::LEAD_LO + 16'd1,  1'b0, 1'b0, 1'b0, 1'b0, 8'd0},
        '{LVL_HIGH, nirpd_pkg::SPACE_LO,         1'b1, 1'b0, 1'b0, 1'b1, 8'd0},
        '{LVL_LOW,  16'd1,                       1'b0, 1'b0, 1'b0, 1'b0, 8'd0},
        '{LVL_HIGH, nirpd_pkg::LEAD_HI - 16'd1,  1'b0, 1'b0, 1'b0, 1'b0, 8'd0},
        '{LVL_LOW,  nirpd_pkg::RPT_LO,           1'b1, 1'b0, 1'b0, 1'b1, 8'd0},
        '{LVL_LOW,  16'd5,                       1'b0, 1'b0, 1'b0, 1'b0, 8'd0},
        '{LVL_HIGH, 16'd9000,                    1'b0, 1'b0, 1'b0, 1'b0, 8'd0},
        '{LVL_LOW,  16'd2250,                    1'b0, 1'b0, 1'b0, 1'b0, 8'd0},
        '{LVL_HIGH, nirpd_pkg::ZERO_HI,          1'b1, 1'b0, 1'b0, 1'b1, 8'd0},
        '{LVL_LOW,  16'd12000,                   1'b0, 1'b0, 1'b0, 1'b0, 8'd0},
        '{LVL_HIGH, 16'd9000,                    1'b0, 1'b0, 1'b0, 1'b0, 8'd0},
        '{LVL_LOW,  nirpd_pkg::RPT_LO + 16'd1,   1'b0, 1'b0, 1'b0, 1'b0, 8'd0},
        '{LVL_HIGH, nirpd_pkg::ZERO_LO + 16'd1,  1'b1, 1'b0, 1'b1, 1'b0, 8'd1},
        '{LVL_LOW,  16'd30000,                   1'b0, 1'b0, 1'b0, 1'b0, 8'd0},
        '{LVL_HIGH, 16'd8999,                    1'b0, 1'b0, 1'b0, 1'b0, 8'd0},
        '{LVL_LOW,  nirpd_pkg::SPACE_LO - 16'd1, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0},
        '{LVL_LOW,  nirpd_pkg::ZERO_HI - 16'd1,  1'b1, 1'b0, 1'b1, 1'b0, 8'd2},
        '{LVL_LOW,  16'd20000,                   1'b0, 1'b0, 1'b0, 1'b0, 8'd0},
        '{LVL_HIGH, 16'd9001,                    1'b0, 1'b0, 1'b0, 1'b0, 8'd0},
        '{LVL_HIGH, nirpd_pkg::SPACE_HI,         1'b1, 1'b0, 1'b0, 1'b1, 8'd0}
    };

    localparam logic [WW-1:0] WINDOW_EDGES[9] = '{
        nirpd_pkg::ONE_LO, nirpd_pkg::ONE_HI, nirpd_pkg::ZERO_LO, nirpd_pkg::ZERO_HI,
        nirpd_pkg::LEAD_LO, nirpd_pkg::LEAD_HI, nirpd_pkg::SPACE_LO, nirpd_pkg::SPACE_HI,
        nirpd_pkg::RPT_LO
    };

    logic                 clk;
    logic                 rst_n        = 1'b0;
    logic                 item_valid   = 1'b0;
    logic                 line_level   = 1'b0;
    logic [WW-1:0]        pulse_width  = '0;
    logic                 result_ready = 1'b0;
    logic                 item_ready;
    logic                 result_valid;
    logic                 frame_done;
    logic                 repeat_done;
    logic                 protocol_error;
    logic [BW-1:0]        first_byte;
    logic [BW-1:0]        second_byte;
    logic [BW-1:0]        third_byte;
    logic [BW-1:0]        fourth_byte;
    logic [BW-1:0]        repeat_count;

    logic                  pd_data_phase = 1'b0;
    logic [CW-1:0]         pd_edge_cnt   = '0;
    logic [NB-1:0][BW-1:0] pd_bytes      = '0;
    logic [BW-1:0]         pd_repeats    = '0;

    ir_result_t pending_decodes[$];
    int         mismatches    = 0;
    int         edges_counted = 0;
    logic       fast_send     = 1'b0;
    logic       fast_recv     = 1'b0;

    nec_ir_pulse_decoder_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .line_level     (line_level),
        .pulse_width    (pulse_width),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .frame_done     (frame_done),
        .repeat_done    (repeat_done),
        .protocol_error (protocol_error),
        .first_byte     (first_byte),
        .second_byte    (second_byte),
        .third_byte     (third_byte),
        .fourth_byte    (fourth_byte),
        .repeat_count   (repeat_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic in_window(input logic [WW-1:0] w,
                                       input logic [WW-1:0] lo,
                                       input logic [WW-1:0] hi);
        return (w > lo) && (w < hi);
    endfunction

    function automatic void drop_frame();
        pd_data_phase = 1'b0;
        pd_edge_cnt   = AWAIT_FALL;
        pd_repeats    = '0;
    endfunction

    function automatic ir_result_t decode_edge(input logic lvl, input logic [WW-1:0] w);
        ir_result_t r;
        logic       is_one;
        int         idx;
        r = '0;
        if (pd_data_phase)
        begin
            pd_edge_cnt = pd_edge_cnt + 7'd1;
            if (lvl == LVL_LOW)
            begin
                is_one = in_window(w, nirpd_pkg::ONE_LO, nirpd_pkg::ONE_HI);
                if (!is_one && !in_window(w, nirpd_pkg::ZERO_LO, nirpd_pkg::ZERO_HI))
                begin
                    drop_frame();
                    r.protocol_error = 1'b1;
                end
                else if (pd_edge_cnt >= 7'd1 && pd_edge_cnt <= nirpd_pkg::DATA_EDGES)
                begin
                    idx = (int'(pd_edge_cnt) - 1) / int'(nirpd_pkg::EDGES_PER_BYTE);
                    pd_bytes[idx] = {pd_bytes[idx][BW-2:0], is_one};
                end
            end
            if (!r.protocol_error && pd_edge_cnt == nirpd_pkg::END_EDGE)
            begin
                pd_data_phase = 1'b0;
                pd_edge_cnt   = AWAIT_FALL;
                pd_repeats    = pd_repeats + 8'd1;
                r.frame_done  = 1'b1;
            end
        end
        else
        begin
            case (pd_edge_cnt)
                AWAIT_FALL:
                begin
                    if (lvl == LVL_LOW)
                        pd_edge_cnt = AWAIT_MARK;
                end
                AWAIT_MARK:
                begin
                    if (in_window(w, nirpd_pkg::LEAD_LO, nirpd_pkg::LEAD_HI))
                        pd_edge_cnt = AWAIT_SPACE;
                    else
                    begin
                        drop_frame();
                        r.protocol_error = 1'b1;
                    end
                end
                AWAIT_SPACE:
                begin
                    if (in_window(w, nirpd_pkg::SPACE_LO, nirpd_pkg::SPACE_HI))
                    begin
                        pd_data_phase = 1'b1;
                        pd_edge_cnt   = '0;
                        pd_repeats    = '0;
                    end
                    else if (in_window(w, nirpd_pkg::RPT_LO, nirpd_pkg::SPACE_LO))
                        pd_edge_cnt = AWAIT_TAIL;
                    else
                    begin
                        drop_frame();
                        r.protocol_error = 1'b1;
                    end
                end
                AWAIT_TAIL:
                begin
                    if (in_window(w, nirpd_pkg::ZERO_LO, nirpd_pkg::ZERO_HI))
                    begin
                        pd_repeats    = pd_repeats + 8'd1;
                        pd_edge_cnt   = AWAIT_FALL;
                        r.repeat_done = 1'b1;
                    end
                    else
                    begin
                        drop_frame();
                        r.protocol_error = 1'b1;
                    end
                end
                default:
                    pd_edge_cnt = AWAIT_FALL;
            endcase
        end
        r.data         = pd_bytes;
        r.repeat_count = pd_repeats;
        return r;
    endfunction

    function automatic logic [WW-1:0] pick_inside(input logic [WW-1:0] lo,
                                                  input logic [WW-1:0] hi);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return lo + 16'd1;
        if (r == 1)
            return hi - 16'd1;
        return WW'($urandom_range(int'(lo) + 1, int'(hi) - 1));
    endfunction

    function automatic logic [WW-1:0] bad_bit_width();
        case ($urandom_range(0, 6))
            0: return nirpd_pkg::ZERO_LO;
            1: return nirpd_pkg::ZERO_HI;
            2: return nirpd_pkg::ONE_LO;
            3: return nirpd_pkg::ONE_HI;
            4: return WW'($urandom_range(int'(nirpd_pkg::ZERO_HI) + 1,
                                         int'(nirpd_pkg::ONE_LO) - 1));
            5: return WW'($urandom_range(int'(nirpd_pkg::ONE_HI) + 1, 65535));
            default: return WW'($urandom_range(0, int'(nirpd_pkg::ZERO_LO) - 1));
        endcase
    endfunction

    function automatic logic [WW-1:0] near_limit();
        logic [WW-1:0] c;
        if ($urandom_range(0, 1))
            return WW'($urandom_range(0, 65535));
        c = WINDOW_EDGES[$urandom_range(0, 8)];
        return c + WW'($urandom_range(0, 2)) - 16'd1;
    endfunction

    function automatic logic [WW-1:0] mark_width();
        if ($urandom_range(0, 4) == 0)
            return WW'($urandom_range(0, 65535));
        return pick_inside(nirpd_pkg::ZERO_LO, nirpd_pkg::ZERO_HI);
    endfunction

    function automatic logic [WW-1:0] bit_width(input logic is_one);
        return is_one ? pick_inside(nirpd_pkg::ONE_LO, nirpd_pkg::ONE_HI)
                      : pick_inside(nirpd_pkg::ZERO_LO, nirpd_pkg::ZERO_HI);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic send_edge(input logic lvl, input logic [WW-1:0] w);
        int gap;
        gap = fast_send ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid  <= 1'b1;
        line_level  <= lvl;
        pulse_width <= w;
        do @(posedge clk); while (!item_ready);
        if (!(lvl == LVL_HIGH && !pd_data_phase && pd_edge_cnt == AWAIT_FALL))
            edges_counted++;
        pending_decodes.push_back(decode_edge(lvl, w));
    endtask

    task automatic send_frame(input logic [31:0] payload, input frame_flaw_t flaw);
        int spot;
        spot = $urandom_range(0, 31);
        send_edge(LVL_LOW, WW'($urandom_range(0, 65535)));
        send_edge(LVL_HIGH, pick_inside(nirpd_pkg::LEAD_LO, nirpd_pkg::LEAD_HI));
        send_edge(LVL_LOW, pick_inside(nirpd_pkg::SPACE_LO, nirpd_pkg::SPACE_HI));
        for (int i = 0; i < 32; i++)
        begin
            send_edge(LVL_HIGH, mark_width());
            if (flaw == FLAW_EXTRA_EDGE && i == spot)
            begin
                if ($urandom_range(0, 1))
                    send_edge(LVL_HIGH, mark_width());
                else
                    send_edge(LVL_LOW, bit_width(1'($urandom_range(0, 1))));
            end
            if (flaw == FLAW_BAD_BIT && i == spot)
            begin
                send_edge(LVL_LOW, bad_bit_width());
                return;
            end
            send_edge(LVL_LOW, bit_width(payload[31-i]));
        end
        if (flaw == FLAW_FALLING_END)
            send_edge(LVL_LOW, $urandom_range(0, 1) ? bit_width(1'($urandom_range(0, 1)))
                                                    : bad_bit_width());
        else
            send_edge(LVL_HIGH, mark_width());
    endtask

    task automatic send_repeat(input logic flawed);
        send_edge(LVL_LOW, WW'($urandom_range(0, 65535)));
        send_edge(LVL_HIGH, pick_inside(nirpd_pkg::LEAD_LO, nirpd_pkg::LEAD_HI));
        send_edge(LVL_LOW, pick_inside(nirpd_pkg::RPT_LO, nirpd_pkg::SPACE_LO));
        send_edge(LVL_HIGH, flawed ? bad_bit_width()
                                   : pick_inside(nirpd_pkg::ZERO_LO, nirpd_pkg::ZERO_HI));
    endtask

    // stimulus
    initial
    begin
        int          pick;
        logic        paused;
        frame_flaw_t flaw;
        paused = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            send_edge(DIRECTED[i].lvl, DIRECTED[i].w);
            if (DIRECTED[i].typed)
                pending_decodes[pending_decodes.size()-1] =
                    '{DIRECTED[i].fd, DIRECTED[i].rd, DIRECTED[i].er, '0, DIRECTED[i].rc};
        end

        edges_counted = 0;
        while (edges_counted < RANDOM_EDGES)
        begin
            fast_send = ($urandom_range(0, 4) == 0);
            if (!paused && edges_counted >= PAUSE_AT_EDGES)
            begin
                paused = 1'b1;
                item_valid <= 1'b0;
                wait (pending_decodes.size() == 0);
                @(posedge clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                case ($urandom_range(0, 9))
                    0, 1:    flaw = FLAW_BAD_BIT;
                    2:       flaw = FLAW_EXTRA_EDGE;
                    3:       flaw = FLAW_FALLING_END;
                    default: flaw = FLAW_NONE;
                endcase
                send_frame($urandom, flaw);
            end
            else if (pick < 70)
            begin
                repeat ($urandom_range(1, 3))
                    send_repeat($urandom_range(0, 7) == 0);
            end
            else if (pick < 85)
            begin
                send_edge(LVL_LOW, WW'($urandom_range(0, 65535)));
                send_edge(LVL_HIGH, near_limit());
                if ($urandom_range(0, 1))
                    send_edge(LVL_LOW, near_limit());
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    send_edge(1'($urandom_range(0, 1)), near_limit());
            end
        end

        item_valid <= 1'b0;
        wait (pending_decodes.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // result side
    initial
    begin
        int         stall;
        int         taken;
        ir_result_t got;
        ir_result_t want;
        taken = 0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (taken % 64 == 0)
                fast_recv = ($urandom_range(0, 3) == 0);
            if (taken == LONG_HOLD_AT)
                stall = LONG_HOLD_CYCLES;
            else
                stall = fast_recv ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
            taken++;
            got = '{frame_done, repeat_done, protocol_error,
                    {fourth_byte, third_byte, second_byte, first_byte}, repeat_count};
            if (pending_decodes.size() == 0)
                report_mismatch("result transaction with nothing expected");
            else
            begin
                want = pending_decodes.pop_front();
                check_field("frame_done", got.frame_done, want.frame_done);
                check_field("repeat_done", got.repeat_done, want.repeat_done);
                check_field("protocol_error", got.protocol_error, want.protocol_error);
                check_field("first_byte", got.data[0], want.data[0]);
                check_field("second_byte", got.data[1], want.data[1]);
                check_field("third_byte", got.data[2], want.data[2]);
                check_field("fourth_byte", got.data[3], want.data[3]);
                check_field("repeat_count", got.repeat_count, want.repeat_count);
            end
        end
    end

    // watchdog on cycles without any transaction
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && item_ready) || (result_valid && result_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
    end

endmodule
